// ===== sv/msli_pkg.sv =====
// Shared types, constants and codes for the multi-servo linear interpolator.
`timescale 1ns / 1ps
`default_nettype none

package msli_pkg;

  // Channel and field sizes.
  localparam int CHANNELS      = 16;
  localparam int FRACTION_BITS = 16;
  localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHAN_FIELD_W  = 4;
  localparam int PULSE_W       = 12;
  localparam int TICK_W        = 10;
  localparam int DUR_W         = 16;
  localparam int FUNC_W        = 2;

  // Reset value of the tick length register, in milliseconds.
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10);

  // Datapath widths derived from the field sizes.
  localparam int PROD_W     = PULSE_W + TICK_W;
  localparam int DIVIDEND_W = PROD_W + FRACTION_BITS;
  localparam int DIVISOR_W  = DUR_W;
  localparam int QUOT_W     = PULSE_W + FRACTION_BITS;
  localparam int STEP_W     = QUOT_W + 1;
  localparam int RUN_W      = STEP_W + 1;
  localparam int WHOLE_W    = RUN_W - FRACTION_BITS;

  // Input function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGO,
    ST_TWAIT,
    ST_MUL,
    ST_SGO,
    ST_SWAIT,
    ST_EMIT
  } state_t;

  // Input transaction payload.
  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [CHAN_FIELD_W-1:0] channel;
    logic [PULSE_W-1:0]      target_pulse;
    logic [DUR_W-1:0]        duration_ms;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [CHAN_FIELD_W-1:0] servo_index;
    logic [PULSE_W-1:0]      pulse;
    logic                    last;
  } out_item_t;

  // Request to the shared divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/msli_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msli_div import msli_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0]    quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   trial_sub;
  logic                 fits;

  // One trial subtraction of the divisor from the shifted remainder.
  assign trial     = {rem_r, quo_r[QUOT_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = (trial >= {1'b0, dvs_r});

  // The callers guarantee the quotient fits in QUOT_W bits, so the top bits
  // of the dividend start out as a remainder below the divisor.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = DIVISOR_W'(req.dividend[DIVIDEND_W-1:QUOT_W]);
      quo_nxt  = req.dividend[QUOT_W-1:0];
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[QUOT_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the datapath needs none.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/multi_servo_linear_interpolator.sv =====
// Top level of the multi-servo linear interpolator: sequencer, channel state, result register.
//
// Usage: input transactions (in_valid/in_ready/in_data) carry a function code.
// A load writes one channel target. A start whose duration is at most one
// tick emits all targets as 16 results and commits them. A longer start
// computes ceil(duration/tick) and one Q16 step per channel on the shared
// divider, one quotient bit per cycle, with no results. A tick while a move
// runs emits one result per channel, channel 0 first, the final one marked
// with last, at one result per cycle while out_ready stays high. Idle ticks,
// busy loads and starts, and unused codes give nothing. in_ready is high
// only while the sequencer is idle. A stalled receiver (out_ready low) holds
// the output register and the burst pauses in place; nothing is lost. The
// tick length is written through cfg_we/cfg_wdata; the user must keep such
// writes to idle times, as the block has no check for it; zero counts as one.
// Synchronous active-low reset clears all channel state, the tick length
// returns to 10 ms and the block starts idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

module multi_servo_linear_interpolator import msli_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [TICK_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  // Channel state.
  logic [PULSE_W-1:0]       target_r [CHANNELS];
  logic [PULSE_W-1:0]       commit_r [CHANNELS];
  logic signed [STEP_W-1:0] step_r   [CHANNELS];
  logic signed [RUN_W-1:0]  run_r    [CHANNELS];

  // Move control and latched operands.
  logic [TICK_W-1:0] tick_ms_r;
  logic [DUR_W-1:0]  ticks_left_r;
  logic              moving_r;
  logic              emit_tick_r;
  logic [CH_W-1:0]   ch_r;
  logic [DUR_W-1:0]  dur_r;
  logic [TICK_W-1:0] t_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              in_fire;
  logic [TICK_W-1:0] t_eff;
  logic              short_move;
  logic              go_load, go_jump, go_move, go_tick;
  logic              emit_adv;
  logic              ch_last;
  logic              final_tick;

  logic [PULSE_W-1:0]       cur_target;
  logic [PULSE_W-1:0]       cur_commit;
  logic signed [PULSE_W:0]  diff;
  logic [PULSE_W-1:0]       diff_mag;
  logic [DUR_W:0]           tick_sum;
  logic [STEP_W-1:0]        step_mag;
  logic signed [STEP_W-1:0] step_new;
  logic signed [RUN_W-1:0]  run_new;
  logic signed [WHOLE_W-1:0] whole;
  logic [PULSE_W-1:0]       tick_pulse;

  // Shared divider.
  msli_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Input decode.
  assign in_fire    = in_valid && in_ready;
  assign t_eff      = (tick_ms_r == '0) ? TICK_W'(1) : tick_ms_r;
  assign short_move = (in_data.duration_ms <= DUR_W'(t_eff));

  always_comb begin
    go_load = 1'b0;
    go_jump = 1'b0;
    go_move = 1'b0;
    go_tick = 1'b0;
    unique case (in_data.func)
      FUNC_LOAD: begin
        go_load = in_fire && !moving_r && (32'(in_data.channel) < CHANNELS);
      end
      FUNC_START: begin
        go_jump = in_fire && !moving_r && short_move;
        go_move = in_fire && !moving_r && !short_move;
      end
      FUNC_TICK: begin
        go_tick = in_fire && moving_r;
      end
      default: begin
      end
    endcase
  end

  // Per-channel arithmetic on the channel the counter selects.
  assign ch_last    = (ch_r == CH_W'(CHANNELS - 1));
  assign cur_target = target_r[ch_r];
  assign cur_commit = commit_r[ch_r];
  assign diff       = $signed({1'b0, cur_target}) - $signed({1'b0, cur_commit});
  assign diff_mag   = diff[PULSE_W] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
  assign tick_sum   = {1'b0, dur_r} + (DUR_W + 1)'(t_r) - (DUR_W + 1)'(1);
  assign step_mag   = {1'b0, div_rsp.quotient};
  assign step_new   = neg_r ? -$signed(step_mag) : $signed(step_mag);
  assign run_new    = run_r[ch_r] + RUN_W'(step_r[ch_r]);
  assign whole      = $signed(run_new[RUN_W-1:FRACTION_BITS]);
  assign final_tick = emit_tick_r && (ticks_left_r <= DUR_W'(1));

  // Floor of the running position, saturated to the pulse range.
  always_comb begin
    if (whole[WHOLE_W-1]) begin
      tick_pulse = '0;
    end else if (whole[WHOLE_W-2:PULSE_W] != '0) begin
      tick_pulse = '1;
    end else begin
      tick_pulse = whole[PULSE_W-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go_jump || go_tick) begin
          state_nxt = ST_EMIT;
        end else if (go_move) begin
          state_nxt = ST_TGO;
        end
      end
      ST_TGO:   state_nxt = ST_TWAIT;
      ST_TWAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_SGO;
      ST_SGO:   state_nxt = ST_SWAIT;
      ST_SWAIT: begin
        if (div_rsp.done) begin
          state_nxt = ch_last ? ST_IDLE : ST_MUL;
        end
      end
      ST_EMIT: begin
        if (emit_adv && ch_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready         = 1'b0;
    emit_adv         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {prod_r, FRACTION_BITS'(0)};
    div_req.divisor  = dur_r;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_TGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVIDEND_W'(tick_sum);
        div_req.divisor  = DIVISOR_W'(t_r);
      end
      ST_SGO:  div_req.start = 1'b1;
      ST_EMIT: emit_adv = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // State, channel store and move control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_ms_r    <= TICK_RESET;
      ticks_left_r <= '0;
      moving_r     <= 1'b0;
      emit_tick_r  <= 1'b0;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        target_r[i] <= '0;
        commit_r[i] <= '0;
        step_r[i]   <= '0;
        run_r[i]    <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        tick_ms_r <= cfg_wdata;
      end

      if (go_load) begin
        target_r[in_data.channel[CH_W-1:0]] <= in_data.target_pulse;
      end

      // A burst always begins at channel 0.
      if (go_jump || go_tick) begin
        ch_r        <= '0;
        emit_tick_r <= go_tick;
      end

      // The tick count is done; the step sweep begins at channel 0.
      if (state_r == ST_TWAIT && div_rsp.done) begin
        ticks_left_r <= div_rsp.quotient[DUR_W-1:0];
        ch_r         <= '0;
      end

      // Store one channel's step and starting position.
      if (state_r == ST_SWAIT && div_rsp.done) begin
        step_r[ch_r] <= step_new;
        run_r[ch_r]  <= RUN_W'({cur_commit, FRACTION_BITS'(0)});
        if (ch_last) begin
          moving_r <= 1'b1;
          ch_r     <= '0;
        end else begin
          ch_r <= ch_r + 1'b1;
        end
      end

      // Emit one result per cycle when not stalled; commit targets channel by channel.
      if (emit_adv) begin
        if (emit_tick_r) begin
          run_r[ch_r] <= run_new;
        end
        if (!emit_tick_r || final_tick) begin
          commit_r[ch_r] <= cur_target;
        end
        if (ch_last) begin
          ch_r <= '0;
          if (emit_tick_r) begin
            if (ticks_left_r != '0) begin
              ticks_left_r <= ticks_left_r - 1'b1;
            end
            if (final_tick) begin
              moving_r <= 1'b0;
            end
          end
        end else begin
          ch_r <= ch_r + 1'b1;
        end
      end

      // Output register: loaded by the burst, cleared when taken.
      if (emit_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // Latched operands and result payload.
    if (go_move) begin
      dur_r <= in_data.duration_ms;
      t_r   <= t_eff;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(diff_mag) * PROD_W'(t_r);
      neg_r  <= diff[PULSE_W];
    end
    if (emit_adv) begin
      out_data_r.servo_index <= CHAN_FIELD_W'(ch_r);
      out_data_r.pulse       <= emit_tick_r ? tick_pulse : cur_target;
      out_data_r.last        <= ch_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_TWAIT || state_r == ST_SWAIT))
    else $error("divider finished outside a wait state");

  // An armed move always has ticks left between bursts.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && moving_r) |-> (ticks_left_r != '0))
    else $error("move armed with no ticks left");

  // A jump burst never runs while a move is armed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !emit_tick_r) |-> !moving_r)
    else $error("jump burst during a move");

  // The marked result is always the highest channel.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |->
      (out_data_r.servo_index == CHAN_FIELD_W'(CHANNELS - 1)))
    else $error("last result on the wrong channel");

endmodule

`default_nettype wire

// ===== verif/tb_multi_servo_linear_interpolator.sv =====
// Self-checking testbench for the multi-servo linear interpolator with a built-in predictor.
`timescale 1ns / 1ps

module tb_multi_servo_linear_interpolator;
  import msli_pkg::*;

  // Selector value that the block has to ignore.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int          PULSE_MAX        = (1 << PULSE_W) - 1;
  localparam int          DUR_MAX          = (1 << DUR_W) - 1;
  localparam int          SETTLE_CYCLES    = 700;
  localparam int          LONG_HOLD_AT     = 40;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          MAX_IDLE         = 13;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int          PHASE_QUOTA      = 5;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [TICK_W-1:0] cfg_wdata = TICK_RESET;

  // Commands waiting to be driven and results waiting to be seen.
  in_item_t  servo_cmd_q[$];
  out_item_t expected_pulse_q[$];

  // Predictor copy of the channel state and the tick register.
  logic [PULSE_W-1:0] tgt_pulse[CHANNELS];
  logic [PULSE_W-1:0] pos_pulse[CHANNELS];
  longint             step_fx[CHANNELS];
  longint             run_fx[CHANNELS];
  longint             ticks_remaining;
  bit                 move_active;
  logic [TICK_W-1:0]  tick_len_model;

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  int unsigned drv_gap        = 0;
  int unsigned drv_draws      = 0;
  bit          drv_fast       = 1'b0;
  int unsigned rcv_hold       = 0;
  int unsigned rcv_draws      = 0;
  bit          rcv_fast       = 1'b0;

  multi_servo_linear_interpolator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock.
  always #5 clk = ~clk;

  // Run ends here, reported as a failure, when the cycle counter reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic in_item_t servo_cmd(logic [FUNC_W-1:0] f, int unsigned ch,
                                         int unsigned p, int unsigned d);
    in_item_t it;
    it.func         = f;
    it.channel      = CHAN_FIELD_W'(ch);
    it.target_pulse = PULSE_W'(p);
    it.duration_ms  = DUR_W'(d);
    return it;
  endfunction

  // Works out the results of one accepted transaction and updates the model state.
  function automatic void predict_servo_item(in_item_t cmd);
    longint    t;
    longint    diff;
    longint    whole;
    out_item_t r;
    t = (tick_len_model == '0) ? 64'sd1 : longint'(tick_len_model);
    case (cmd.func)
      FUNC_LOAD: begin
        if (!move_active && int'(cmd.channel) < CHANNELS)
          tgt_pulse[cmd.channel] = cmd.target_pulse;
      end
      FUNC_START: begin
        if (!move_active) begin
          if (longint'(cmd.duration_ms) <= t) begin
            // Short move: jump straight to the targets.
            for (int i = 0; i < CHANNELS; i++) begin
              r.servo_index = CHAN_FIELD_W'(i);
              r.pulse       = tgt_pulse[i];
              r.last        = (i == CHANNELS - 1);
              expected_pulse_q.push_back(r);
              pos_pulse[i]  = tgt_pulse[i];
            end
          end else begin
            for (int i = 0; i < CHANNELS; i++) begin
              diff       = longint'(tgt_pulse[i]) - longint'(pos_pulse[i]);
              step_fx[i] = (diff * t * (64'sd1 << FRACTION_BITS))
                           / longint'(cmd.duration_ms);
              run_fx[i]  = longint'(pos_pulse[i]) << FRACTION_BITS;
            end
            ticks_remaining = (longint'(cmd.duration_ms) + t - 1) / t;
            move_active     = 1'b1;
          end
        end
      end
      FUNC_TICK: begin
        if (move_active) begin
          // One interpolation step per channel, floored and clamped to the pulse range.
          for (int i = 0; i < CHANNELS; i++) begin
            run_fx[i] = run_fx[i] + step_fx[i];
            whole     = run_fx[i] >>> FRACTION_BITS;
            r.servo_index = CHAN_FIELD_W'(i);
            if (whole < 0)
              r.pulse = '0;
            else if (whole > PULSE_MAX)
              r.pulse = PULSE_W'(PULSE_MAX);
            else
              r.pulse = PULSE_W'(whole);
            r.last = (i == CHANNELS - 1);
            expected_pulse_q.push_back(r);
          end
          if (ticks_remaining > 0)
            ticks_remaining = ticks_remaining - 1;
          if (ticks_remaining == 0) begin
            for (int i = 0; i < CHANNELS; i++)
              pos_pulse[i] = tgt_pulse[i];
            move_active = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < 10)
      $display("MISMATCH: %s", what);
    mismatch_count++;
  endtask

  // Driver: presents queued commands, with a random gap between commands.
  always @(posedge clk) begin : cmd_driver
    int unsigned gap;
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap  <= 0;
    end else begin
      if (in_valid && in_ready)
        predict_servo_item(in_data);
      if (!in_valid || in_ready) begin
        if (drv_gap != 0) begin
          drv_gap  <= drv_gap - 1;
          in_valid <= 1'b0;
        end else if (servo_cmd_q.size() != 0) begin
          if (drv_draws % 24 == 0)
            drv_fast = ($urandom_range(0, 3) == 0);
          drv_draws++;
          gap = drv_fast ? 0 : $urandom_range(0, MAX_IDLE);
          in_data  <= servo_cmd_q.pop_front();
          in_valid <= 1'b1;
          drv_gap  <= gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and stalls the result channel at random.
  always @(posedge clk) begin : result_monitor
    out_item_t   want;
    int unsigned hold;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rcv_hold  <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_pulse_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result servo %0d pulse %0d last %0b",
                                out_data.servo_index, out_data.pulse, out_data.last));
      end else begin
        want = expected_pulse_q.pop_front();
        if (out_data.servo_index !== want.servo_index || out_data.pulse !== want.pulse ||
            out_data.last !== want.last)
          flag_mismatch($sformatf(
            "expected servo %0d pulse %0d last %0b, got servo %0d pulse %0d last %0b",
            want.servo_index, want.pulse, want.last,
            out_data.servo_index, out_data.pulse, out_data.last));
      end
      results_seen++;
      if (results_seen == LONG_HOLD_AT) begin
        // One long hold-off so the block backs up and blocks its input.
        hold = LONG_HOLD_CYCLES;
      end else begin
        if (rcv_draws % 24 == 0)
          rcv_fast = ($urandom_range(0, 3) == 0);
        rcv_draws++;
        hold = rcv_fast ? 0 : $urandom_range(0, MAX_IDLE);
      end
      rcv_hold  <= hold;
      out_ready <= (hold == 0);
    end else if (rcv_hold != 0) begin
      rcv_hold  <= rcv_hold - 1;
      out_ready <= (rcv_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Waits until every command is taken and every result is in, then lets a long start finish.
  task automatic wait_settle();
    while (servo_cmd_q.size() != 0 || in_valid || expected_pulse_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_len(int unsigned v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= TICK_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tick_len_model = TICK_W'(v);
  endtask

  function automatic int unsigned pick_pulse();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return PULSE_MAX;
      default: return $urandom_range(0, PULSE_MAX);
    endcase
  endfunction

  function automatic int unsigned pick_duration(int unsigned t);
    int unsigned d;
    case ($urandom_range(0, 9))
      0: d = $urandom_range(0, t);
      1: d = t + 1;
      2: d = (t >= 512) ? $urandom_range(0, DUR_MAX) : t * $urandom_range(2, 6);
      default: d = t * $urandom_range(1, 5) + $urandom_range(0, t - 1);
    endcase
    return d;
  endfunction

  // Queues well-formed moves (loads, a start, exactly enough ticks) with noise mixed in.
  task automatic queue_random_moves(int unsigned quota);
    int unsigned counted;
    int unsigned t;
    int unsigned dur;
    int unsigned n_ticks;
    counted = 0;
    t = (tick_len_model == '0) ? 1 : int'(tick_len_model);
    while (counted < quota) begin
      repeat ($urandom_range(0, 4)) begin
        servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, $urandom_range(0, CHANNELS - 1),
                                        pick_pulse(), $urandom_range(0, DUR_MAX)));
        counted++;
      end
      if ($urandom_range(0, 4) == 0)
        servo_cmd_q.push_back(servo_cmd($urandom_range(0, 1) ? FUNC_UNUSED : FUNC_TICK,
                                        $urandom_range(0, 15), $urandom_range(0, PULSE_MAX),
                                        $urandom_range(0, DUR_MAX)));
      dur = pick_duration(t);
      servo_cmd_q.push_back(servo_cmd(FUNC_START, $urandom_range(0, 15),
                                      $urandom_range(0, PULSE_MAX), dur));
      counted++;
      n_ticks = (dur <= t) ? 0 : (dur + t - 1) / t;
      for (int k = 0; k < n_ticks; k++) begin
        servo_cmd_q.push_back(servo_cmd(FUNC_TICK, $urandom_range(0, 15),
                                        $urandom_range(0, PULSE_MAX),
                                        $urandom_range(0, DUR_MAX)));
        counted++;
        // Loads and starts in the middle of a move must be dropped.
        if ($urandom_range(0, 3) == 0)
          servo_cmd_q.push_back(servo_cmd($urandom_range(0, 1) ? FUNC_LOAD : FUNC_START,
                                          $urandom_range(0, 15), pick_pulse(),
                                          $urandom_range(0, DUR_MAX)));
      end
    end
  endtask

  // Main sequence: reset, directed commands, then random moves under several tick lengths.
  initial begin : main_seq
    int unsigned tick_settings[5];
    for (int i = 0; i < CHANNELS; i++) begin
      tgt_pulse[i] = '0;
      pos_pulse[i] = '0;
      step_fx[i]   = 0;
      run_fx[i]    = 0;
    end
    ticks_remaining = 0;
    move_active     = 1'b0;
    tick_len_model  = TICK_RESET;
    tick_settings   = '{1000, 0, 1, 1023, 37};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Idle tick and unused selector with all fields at their maximum.
    servo_cmd_q.push_back(servo_cmd(FUNC_TICK, 15, PULSE_MAX, DUR_MAX));
    servo_cmd_q.push_back(servo_cmd(FUNC_UNUSED, 15, PULSE_MAX, DUR_MAX));
    // Zero-length move from reset state.
    servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, 0));
    // Upward move that overshoots and clamps at the top.
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 0, PULSE_MAX, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 15, PULSE_MAX, DUR_MAX));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 7, 2048, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 1, 1, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, 35));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 0, 0, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, 0));
    repeat (4) servo_cmd_q.push_back(servo_cmd(FUNC_TICK, 0, 0, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_TICK, 0, 0, 0));
    // Downward move that goes below zero and clamps at the bottom.
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 0, 0, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 15, 0, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 7, PULSE_MAX, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, 11));
    repeat (2) servo_cmd_q.push_back(servo_cmd(FUNC_TICK, 0, 0, 0));
    // Duration equal to one tick jumps at once.
    servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 3, 1234, 0));
    servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, 10));
    wait_settle();

    foreach (tick_settings[p]) begin
      write_tick_len(tick_settings[p]);
      if (tick_settings[p] == 1000) begin
        // Longest duration in one go.
        servo_cmd_q.push_back(servo_cmd(FUNC_LOAD, 5, PULSE_MAX, 0));
        servo_cmd_q.push_back(servo_cmd(FUNC_START, 0, 0, DUR_MAX));
        repeat ((DUR_MAX + 999) / 1000) servo_cmd_q.push_back(servo_cmd(FUNC_TICK, 0, 0, 0));
      end
      queue_random_moves(PHASE_QUOTA);
      wait_settle();
    end

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
sv/msli_pkg.sv
sv/msli_div.sv
sv/multi_servo_linear_interpolator.sv
verif/tb_multi_servo_linear_interpolator.sv
